### sv/lfu_pkg.sv
// shared types and constants for the lfu frame replacement block
package lfu_pkg;

    localparam int KEY_W      = 16;
    localparam int HIT_W      = 16;
    localparam int STAMP_W    = 32;
    localparam int LIMIT_W    = 4;
    localparam int RPT_W      = 4;
    localparam int REPORT_MAX = 8;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [HIT_W-1:0]   HIT_MAX     = 16'hFFFF;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

    // register index is paddr[2]
    localparam logic REG_ACTIVE  = 1'b0;

    localparam logic KIND_TOUCH  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [HIT_W-1:0]   hits;
        logic [STAMP_W-1:0] stamp;
    } frame_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic is_report;
        logic issue_last;
        logic out_free;
        logic last_result;
    } sts_t;

endpackage

### sv/lfu_ctrl.sv
// controller state machine for the lfu frame replacement block
module lfu_ctrl
    import lfu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    if (!sts.is_report || sts.last_result)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.load       = in_valid;
                cmd.scan_start = in_valid;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_EMIT:
            begin
                cmd.emit       = sts.out_free;
                // another pass for the next sorted key
                cmd.scan_start = sts.out_free && sts.is_report && !sts.last_result;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### sv/lfu_dp.sv
// datapath: frame memory, scan accumulators and result register
module lfu_dp
    import lfu_pkg::*;
#(
    parameter int FRAMES = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic               kind,
    input  logic [KEY_W-1:0]   touch_key,
    input  logic [LIMIT_W-1:0] active_frames,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [KEY_W-1:0]   entry_key,
    output logic [HIT_W-1:0]   entry_count,
    output logic               entry_valid,
    output logic               was_present,
    output logic               last
);

    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int HELD_W = $clog2(FRAMES + 1);
    localparam int CMP_W  = (HELD_W > RPT_W) ? HELD_W : RPT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);

    frame_t mem [FRAMES];

    logic               kind_reg;
    logic [KEY_W-1:0]   tkey_reg;
    logic [STAMP_W-1:0] stamp_ctr_reg;
    logic [FRAMES-1:0]  used_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               rv_reg;
    logic [IDX_W-1:0]   ridx_reg;
    frame_t             rd_data_reg;

    logic [HELD_W-1:0]  held_reg;
    logic               match_found_reg;
    logic [IDX_W-1:0]   match_idx_reg;
    frame_t             match_frame_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic               victim_found_reg;
    logic [IDX_W-1:0]   victim_idx_reg;
    frame_t             victim_frame_reg;
    logic               best_found_reg;
    frame_t             best_frame_reg;
    logic [KEY_W-1:0]   prev_key_reg;
    logic [RPT_W-2:0]   pass_reg;

    logic               out_valid_reg;
    logic [KEY_W-1:0]   entry_key_reg;
    logic [HIT_W-1:0]   entry_count_reg;
    logic               entry_valid_reg;
    logic               was_present_reg;
    logic               last_reg;

    logic               cur_used;
    logic               hit_take;
    logic               free_take;
    logic               victim_take;
    logic               best_take;
    logic [CMP_W-1:0]   act_ext;
    logic [CMP_W-1:0]   limit;
    logic [CMP_W-1:0]   held_ext;
    logic [CMP_W-1:0]   rpt_len;
    logic               place;
    logic               last_rpt;
    logic               wr_en;
    logic [IDX_W-1:0]   waddr;
    frame_t             wdata;
    logic [KEY_W-1:0]   res_key;
    logic [HIT_W-1:0]   res_count;
    logic               res_valid;
    logic               res_present;
    logic               res_last;

    // compare stage on the registered read
    always_comb
    begin
        cur_used  = used_reg[ridx_reg];
        hit_take  = rv_reg && cur_used && (rd_data_reg.key == tkey_reg);
        free_take = rv_reg && !cur_used && !free_found_reg;
        victim_take = rv_reg && cur_used &&
                      (!victim_found_reg ||
                       (rd_data_reg.hits < victim_frame_reg.hits) ||
                       ((rd_data_reg.hits == victim_frame_reg.hits) &&
                        (rd_data_reg.stamp < victim_frame_reg.stamp)));
        best_take = rv_reg && cur_used &&
                    ((pass_reg == '0) || (rd_data_reg.key > prev_key_reg)) &&
                    (!best_found_reg || (rd_data_reg.key < best_frame_reg.key));
    end

    // limit clamp and report length
    always_comb
    begin
        act_ext  = CMP_W'(active_frames);
        held_ext = CMP_W'(held_reg);
        if (act_ext == '0)
        begin
            limit = CMP_W'(1);
        end
        else if (act_ext > CMP_W'(FRAMES))
        begin
            limit = CMP_W'(FRAMES);
        end
        else
        begin
            limit = act_ext;
        end
        if (held_ext > CMP_W'(REPORT_MAX))
        begin
            rpt_len = CMP_W'(REPORT_MAX);
        end
        else
        begin
            rpt_len = held_ext;
        end
        place    = free_found_reg && (held_ext < limit);
        last_rpt = (held_reg == '0) || ((CMP_W'(pass_reg) + CMP_W'(1)) == rpt_len);
    end

    // frame update for a touch
    always_comb
    begin
        wr_en = cmd.emit && (kind_reg == KIND_TOUCH);
        if (match_found_reg)
        begin
            waddr = match_idx_reg;
            wdata = match_frame_reg;
            if (match_frame_reg.hits != HIT_MAX)
            begin
                wdata.hits = match_frame_reg.hits + HIT_W'(1);
            end
        end
        else
        begin
            waddr = place ? free_idx_reg : victim_idx_reg;
            wdata.key   = tkey_reg;
            wdata.hits  = HIT_W'(1);
            wdata.stamp = stamp_ctr_reg;
        end
    end

    // result forming
    always_comb
    begin
        if (kind_reg == KIND_TOUCH)
        begin
            res_valid   = !match_found_reg && !place;
            res_key     = res_valid ? victim_frame_reg.key : '0;
            res_count   = '0;
            res_present = match_found_reg;
            res_last    = 1'b1;
        end
        else if (best_found_reg)
        begin
            res_valid   = 1'b1;
            res_key     = best_frame_reg.key;
            res_count   = best_frame_reg.hits;
            res_present = 1'b0;
            res_last    = last_rpt;
        end
        else
        begin
            res_valid   = 1'b0;
            res_key     = '0;
            res_count   = '0;
            res_present = 1'b0;
            res_last    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_ctr_reg    <= '0;
            used_reg         <= '0;
            rv_reg           <= 1'b0;
            out_valid_reg    <= 1'b0;
            match_found_reg  <= 1'b0;
            free_found_reg   <= 1'b0;
            victim_found_reg <= 1'b0;
            best_found_reg   <= 1'b0;
            held_reg         <= '0;
            pass_reg         <= '0;
            rd_idx_reg       <= '0;
        end
        else
        begin
            rv_reg <= cmd.scan_step;
            if (cmd.load)
            begin
                pass_reg <= '0;
            end
            else if (cmd.emit && (kind_reg == KIND_REPORT))
            begin
                pass_reg <= pass_reg + 1'b1;
            end
            if (cmd.scan_start)
            begin
                rd_idx_reg       <= '0;
                held_reg         <= '0;
                match_found_reg  <= 1'b0;
                free_found_reg   <= 1'b0;
                victim_found_reg <= 1'b0;
                best_found_reg   <= 1'b0;
            end
            else
            begin
                if (cmd.scan_step)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                if (rv_reg && cur_used)
                begin
                    held_reg <= held_reg + 1'b1;
                end
                if (hit_take)
                begin
                    match_found_reg <= 1'b1;
                end
                if (free_take)
                begin
                    free_found_reg <= 1'b1;
                end
                if (victim_take)
                begin
                    victim_found_reg <= 1'b1;
                end
                if (best_take)
                begin
                    best_found_reg <= 1'b1;
                end
            end
            if (wr_en)
            begin
                stamp_ctr_reg <= stamp_ctr_reg + 1'b1;
                if (!match_found_reg)
                begin
                    used_reg[waddr] <= 1'b1;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            tkey_reg <= touch_key;
        end
        if (cmd.scan_step)
        begin
            rd_data_reg <= mem[rd_idx_reg];
            ridx_reg    <= rd_idx_reg;
        end
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (hit_take)
        begin
            match_idx_reg   <= ridx_reg;
            match_frame_reg <= rd_data_reg;
        end
        if (free_take)
        begin
            free_idx_reg <= ridx_reg;
        end
        if (victim_take)
        begin
            victim_idx_reg   <= ridx_reg;
            victim_frame_reg <= rd_data_reg;
        end
        if (best_take)
        begin
            best_frame_reg <= rd_data_reg;
        end
        if (cmd.emit)
        begin
            prev_key_reg    <= best_frame_reg.key;
            entry_key_reg   <= res_key;
            entry_count_reg <= res_count;
            entry_valid_reg <= res_valid;
            was_present_reg <= res_present;
            last_reg        <= res_last;
        end
    end

    assign sts.is_report   = (kind_reg == KIND_REPORT);
    assign sts.issue_last  = (rd_idx_reg == LAST_IDX);
    assign sts.out_free    = !out_valid_reg || out_ready;
    assign sts.last_result = last_rpt;

    assign out_valid   = out_valid_reg;
    assign entry_key   = entry_key_reg;
    assign entry_count = entry_count_reg;
    assign entry_valid = entry_valid_reg;
    assign was_present = was_present_reg;
    assign last        = last_reg;

endmodule

### sv/lfu_frame_replacement.sv
// top level: config register, controller and datapath of the lfu frame replacement block
// touch item: one scan over all frames, then the drain and emit states load the result
// report item: one full scan over all frames per listed key, up to 8 keys
// a new item is accepted once the last result is loaded; results wait in an output register
// rst_n is asynchronous active low: all frames free, stamp counter zero, active_frames 8
// no clearing pass after reset; frame contents are read only behind their used bits
module lfu_frame_replacement
    import lfu_pkg::*;
#(
    parameter int FRAMES = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [KEY_W-1:0]   touch_key,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [KEY_W-1:0]   entry_key,
    output logic [HIT_W-1:0]   entry_count,
    output logic               entry_valid,
    output logic               was_present,
    output logic               last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [LIMIT_W-1:0] active_reg;
    cmd_t               cmd;
    sts_t               sts;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE))
        begin
            active_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ACTIVE) ? PDATA_W'(active_reg) : '0;

    lfu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lfu_dp #(
        .FRAMES (FRAMES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .kind          (kind),
        .touch_key     (touch_key),
        .active_frames (active_reg),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .entry_key     (entry_key),
        .entry_count   (entry_count),
        .entry_valid   (entry_valid),
        .was_present   (was_present),
        .last          (last)
    );

endmodule

### sv/lfu_checker.sv
// port-level checks for the lfu frame replacement block, bound to the top level
module lfu_checker
    import lfu_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [KEY_W-1:0] entry_key,
    input logic [HIT_W-1:0] entry_count,
    input logic             entry_valid,
    input logic             was_present,
    input logic             last
);

    // one item in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while previous item in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(entry_key) && $stable(last))
        else $error("result dropped or changed while stalled");

    a_empty_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !entry_valid |-> entry_key == '0 && entry_count == '0 && last)
        else $error("result without entry carries data");

    a_hit_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_present |-> !entry_valid && entry_count == '0 && last)
        else $error("hit result malformed");

endmodule

bind lfu_frame_replacement lfu_checker u_lfu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .entry_key   (entry_key),
    .entry_count (entry_count),
    .entry_valid (entry_valid),
    .was_present (was_present),
    .last        (last)
);

### verif/tb_lfu_frame_replacement.sv
// self-checking testbench for the lfu frame replacement block with an lfu scoreboard
`timescale 1ns / 100ps

import lfu_pkg::*;

class frame_scoreboard;
    localparam int NFRAMES = 8;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [HIT_W-1:0] count;
        logic             valid;
        logic             present;
        logic             last;
    } entry_t;

    entry_t               expected_entries[$];
    logic [KEY_W-1:0]     held_key[NFRAMES];
    logic [HIT_W-1:0]     held_hits[NFRAMES];
    logic [STAMP_W-1:0]   held_stamp[NFRAMES];
    bit                   held_used[NFRAMES];
    logic [STAMP_W-1:0]   stamp_ctr;
    logic [LIMIT_W-1:0]   limit_reg;
    int                   errors;

    function new();
        for (int f = 0; f < NFRAMES; f++)
        begin
            held_key[f]   = '0;
            held_hits[f]  = '0;
            held_stamp[f] = '0;
            held_used[f]  = 1'b0;
        end
        stamp_ctr = '0;
        limit_reg = LIMIT_RESET;
        errors    = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
        limit_reg = value;
    endfunction

    function int active_limit();
        int lim;
        lim = limit_reg;
        if (lim < 1)
            lim = 1;
        if (lim > NFRAMES)
            lim = NFRAMES;
        return lim;
    endfunction

    function void push_entry(logic [KEY_W-1:0] key, logic [HIT_W-1:0] count,
                             logic valid, logic present, logic last);
        entry_t e;
        e.key     = key;
        e.count   = count;
        e.valid   = valid;
        e.present = present;
        e.last    = last;
        expected_entries = {expected_entries, e};
    endfunction

    function void predict_touch(logic [KEY_W-1:0] key);
        logic [STAMP_W-1:0] stamp;
        int held;
        int free_slot;
        int victim;
        stamp     = stamp_ctr;
        stamp_ctr = stamp_ctr + 1'b1;
        held      = 0;
        free_slot = -1;
        victim    = -1;
        for (int f = 0; f < NFRAMES; f++)
        begin
            if (held_used[f] && held_key[f] == key)
            begin
                if (held_hits[f] != HIT_MAX)
                    held_hits[f] = held_hits[f] + 1'b1;
                push_entry('0, '0, 1'b0, 1'b1, 1'b1);
                return;
            end
        end
        for (int f = 0; f < NFRAMES; f++)
        begin
            if (held_used[f])
            begin
                held++;
                if (victim < 0 || held_hits[f] < held_hits[victim] ||
                    (held_hits[f] == held_hits[victim] &&
                     held_stamp[f] < held_stamp[victim]))
                    victim = f;
            end
            else if (free_slot < 0)
            begin
                free_slot = f;
            end
        end
        if (held < active_limit() && free_slot >= 0)
        begin
            held_used[free_slot]  = 1'b1;
            held_key[free_slot]   = key;
            held_hits[free_slot]  = HIT_W'(1);
            held_stamp[free_slot] = stamp;
            push_entry('0, '0, 1'b0, 1'b0, 1'b1);
            return;
        end
        if (victim < 0)
            victim = 0;
        push_entry(held_key[victim], '0, 1'b1, 1'b0, 1'b1);
        held_used[victim]  = 1'b1;
        held_key[victim]   = key;
        held_hits[victim]  = HIT_W'(1);
        held_stamp[victim] = stamp;
    endfunction

    function void predict_report();
        logic [KEY_W-1:0] keys[NFRAMES];
        logic [HIT_W-1:0] hits[NFRAMES];
        int n;
        int i;
        int m;
        n = 0;
        for (int f = 0; f < NFRAMES; f++)
        begin
            if (held_used[f])
            begin
                i = n;
                while (i > 0 && keys[i-1] > held_key[f])
                begin
                    keys[i] = keys[i-1];
                    hits[i] = hits[i-1];
                    i--;
                end
                keys[i] = held_key[f];
                hits[i] = held_hits[f];
                n++;
            end
        end
        if (n == 0)
        begin
            push_entry('0, '0, 1'b0, 1'b0, 1'b1);
            return;
        end
        m = (n < REPORT_MAX) ? n : REPORT_MAX;
        for (int j = 0; j < m; j++)
            push_entry(keys[j], hits[j], 1'b1, 1'b0, j == m - 1);
    endfunction

    function void note_item(logic kind, logic [KEY_W-1:0] key);
        if (kind == KIND_REPORT)
            predict_report();
        else
            predict_touch(key);
    endfunction

    task report_mismatch(string msg);
        errors++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_result(logic [KEY_W-1:0] key, logic [HIT_W-1:0] count,
                      logic valid, logic present, logic last);
        entry_t want;
        if (expected_entries.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result key %h count %h", key, count));
            return;
        end
        want = expected_entries.pop_front();
        if (key !== want.key)
            report_mismatch($sformatf("entry_key %h, want %h", key, want.key));
        if (count !== want.count)
            report_mismatch($sformatf("entry_count %h, want %h", count, want.count));
        if (valid !== want.valid)
            report_mismatch($sformatf("entry_valid %b, want %b", valid, want.valid));
        if (present !== want.present)
            report_mismatch($sformatf("was_present %b, want %b", present, want.present));
        if (last !== want.last)
            report_mismatch($sformatf("last %b, want %b", last, want.last));
    endtask
endclass

module tb_lfu_frame_replacement;

    localparam int NFRAMES       = 8;
    localparam int SETTLE_CYCLES = 3 * (NFRAMES + 3);
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOT_TOUCHES   = 8;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 20;
    localparam int POOL_SIZE     = 12;
    localparam logic [PADDR_W-1:0] ADDR_ACTIVE = {REG_ACTIVE, 2'b00};

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               kind = KIND_TOUCH;
    logic [KEY_W-1:0]   touch_key = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [KEY_W-1:0]   entry_key;
    logic [HIT_W-1:0]   entry_count;
    logic               entry_valid;
    logic               was_present;
    logic               last;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    bit                 tx_idle_en = 1'b1;
    bit                 rx_idle_en = 1'b1;
    logic [KEY_W-1:0]   key_pool[POOL_SIZE];
    frame_scoreboard    sb;

    lfu_frame_replacement #(.FRAMES(NFRAMES)) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .touch_key   (touch_key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .entry_key   (entry_key),
        .entry_count (entry_count),
        .entry_valid (entry_valid),
        .was_present (was_present),
        .last        (last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver stalls in random bursts
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (rx_idle_en && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(entry_key, entry_count, entry_valid, was_present, last);
    end

    task automatic send_item(input logic k, input logic [KEY_W-1:0] key);
        kind      <= k;
        touch_key <= key;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_item(k, key);
    endtask

    task automatic idle_cycles(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (sb.expected_entries.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.expected_entries.size() != 0)
        begin
            sb.report_mismatch($sformatf("%0d expected results never came",
                                         sb.expected_entries.size()));
            sb.expected_entries.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_ACTIVE;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_active_frames(input logic [LIMIT_W-1:0] value);
        logic [PDATA_W-1:0] rdata;
        apb_access(1'b1, {$urandom} << LIMIT_W | PDATA_W'(value), rdata);
        sb.set_limit(value);
        apb_access(1'b0, $urandom, rdata);
        if (rdata[LIMIT_W-1:0] !== sb.limit_reg)
            sb.report_mismatch($sformatf("active_frames read %h, want %h",
                                         rdata[LIMIT_W-1:0], sb.limit_reg));
    endtask

    task automatic send_random_item();
        int pick;
        if (tx_idle_en && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 12));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            send_item(KIND_REPORT, KEY_W'($urandom_range(0, 65535)));
        else if (pick <= 6)
            send_item(KIND_TOUCH, key_pool[$urandom_range(0, POOL_SIZE - 1)]);
        else
            send_item(KIND_TOUCH, KEY_W'($urandom_range(0, 65535)));
    endtask

    initial
    begin
        logic [PDATA_W-1:0] rdata;
        logic [KEY_W-1:0]   hot_key;
        logic [LIMIT_W-1:0] phase_limit[PHASES];

        sb = new();
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = KEY_W'($urandom_range(0, 65535));
        phase_limit = '{4'd2, 4'd8, 4'd1, 4'd5, 4'd7};
        phase_limit[3] = LIMIT_W'($urandom_range(0, 15));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of active_frames
        apb_access(1'b0, '0, rdata);
        if (rdata[LIMIT_W-1:0] !== LIMIT_RESET)
            sb.report_mismatch($sformatf("active_frames after reset %h", rdata[LIMIT_W-1:0]));

        // zero limit acts as one, empty report
        set_active_frames(4'd0);
        send_item(KIND_REPORT, 16'hFFFF);
        send_item(KIND_TOUCH, 16'h0000);
        send_item(KIND_TOUCH, 16'h0000);
        send_item(KIND_TOUCH, 16'hFFFF);
        send_item(KIND_REPORT, 16'h0000);
        wait_drained();

        // small limit, lowest count with oldest stamp evicted
        set_active_frames(4'd3);
        send_item(KIND_TOUCH, 16'h5555);
        send_item(KIND_TOUCH, 16'hAAAA);
        send_item(KIND_TOUCH, 16'h5555);
        send_item(KIND_TOUCH, 16'h1234);
        send_item(KIND_REPORT, 16'h0000);
        wait_drained();

        // limit above frame count acts as full bank, full report
        set_active_frames(4'd15);
        send_item(KIND_TOUCH, 16'h00FF);
        send_item(KIND_TOUCH, 16'hFF00);
        send_item(KIND_TOUCH, 16'h8001);
        send_item(KIND_TOUCH, 16'h7F7F);
        send_item(KIND_TOUCH, 16'h0F0F);
        send_item(KIND_TOUCH, 16'hF0F0);
        send_item(KIND_REPORT, 16'h0000);
        wait_drained();

        // limit lowered below held keys: hits still found, misses evict
        set_active_frames(4'd1);
        send_item(KIND_TOUCH, 16'h8001);
        send_item(KIND_TOUCH, 16'h4242);
        send_item(KIND_REPORT, 16'h0000);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            set_active_frames(phase_limit[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 1 && i == PHASE_ITEMS / 2)
                    wait_drained();
                send_random_item();
            end
            wait_drained();
        end

        // no idling from here on
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        set_active_frames(4'd8);

        // repeated hits on one key
        hot_key = KEY_W'($urandom_range(0, 65535));
        for (int i = 0; i <= HOT_TOUCHES; i++)
            send_item(KIND_TOUCH, hot_key);
        send_item(KIND_REPORT, 16'h0000);
        for (int i = 0; i < 10; i++)
            send_random_item();
        send_item(KIND_REPORT, 16'hFFFF);
        wait_drained();

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
